// File: rtl/breakpoint_trap_match_unit_assert.svh
// Assertion macros for the breakpoint/trap match unit.
// Both macros expect clk and rst_n in the scope where they are used.
`ifndef BREAKPOINT_TRAP_MATCH_UNIT_ASSERT_SVH
`define BREAKPOINT_TRAP_MATCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BTMU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BTMU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BTMU_ASSERT_IMP(lbl, ante, cons, msg)
`define BTMU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/btmu_pkg.sv
// Shared types and constants for the breakpoint/trap match unit.
// No dependencies.
package btmu_pkg;

  localparam int BP_ENTRIES_DEF   = 64;
  localparam int TRAP_ENTRIES_DEF = 32;
  localparam int TRAP_BYTES_DEF   = 4;
  localparam int IN_BYTES         = 4;
  localparam int LEN_W            = 3;

  typedef enum logic [2:0] {
    F_CHECK     = 3'd0,
    F_SET_BP    = 3'd1,
    F_RM_BP     = 3'd2,
    F_CLR_BP    = 3'd3,
    F_ADD_TRAP  = 3'd4,
    F_RM_TRAP   = 3'd5,
    F_CLR_TRAP  = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  localparam logic REG_BP_EN   = 1'b0;
  localparam logic REG_TRAP_EN = 1'b1;

  typedef struct packed {
    logic load;
    logic run_start;
    logic run_shift;
    logic apply;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  plen_zero;
    logic  found;
    logic  run_done;
  } stat_t;

endpackage

// File: rtl/btmu_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module btmu_ram #(
  parameter int W = 16,
  parameter int D = 64,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/btmu_ctrl.sv
// Sequencer for the breakpoint/trap match unit: dispatch, scan, shift, done.
// Depends on btmu_pkg and the assertion macro header.
`include "breakpoint_trap_match_unit_assert.svh"
module btmu_ctrl import btmu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  output logic  strobe,
  output cmd_t  cmd,
  input  stat_t stat
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    strobe    = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.func)
          F_CHECK, F_SET_BP, F_RM_BP: begin
            cmd.run_start = 1'b1;
            state_nxt     = S_SCAN;
          end
          F_RM_TRAP: begin
            if (stat.plen_zero) begin
              cmd.apply = 1'b1;
              state_nxt = S_DONE;
            end else begin
              cmd.run_start = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          default: begin
            cmd.apply = 1'b1;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.run_done) begin
          if (stat.found && (stat.func inside {F_RM_BP, F_RM_TRAP})) begin
            cmd.run_start = 1'b1;
            cmd.run_shift = 1'b1;
            state_nxt     = S_SHIFT;
          end else begin
            cmd.apply = 1'b1;
            state_nxt = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        if (stat.run_done) begin
          cmd.apply = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        strobe    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `BTMU_ASSERT_NXT(a_strobe_single, strobe, !strobe, "result strobe longer than one cycle")
  `BTMU_ASSERT_NXT(a_accept_busy, start && !busy, busy && !strobe, "no busy after accept")
  `BTMU_ASSERT_IMP(a_apply_once, cmd.apply, state_nxt == S_DONE, "apply without done")
endmodule

// File: rtl/btmu_dp.sv
// Datapath: item registers, table RAMs, scan/shift pointer, match logic, counts.
// Depends on btmu_pkg, btmu_ram and the assertion macro header.
`include "breakpoint_trap_match_unit_assert.svh"
module btmu_dp import btmu_pkg::*; #(
  parameter int BP_ENTRIES   = BP_ENTRIES_DEF,
  parameter int TRAP_ENTRIES = TRAP_ENTRIES_DEF,
  parameter int TRAP_BYTES   = TRAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        bp_en,
  input  logic        trap_en,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_addr,
  input  logic [2:0]  in_pattern_len,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  input  logic [7:0]  in_byte3,
  output logic        out_bp_hit,
  output logic        out_trap_hit,
  output logic [2:0]  out_status,
  output logic [6:0]  out_bp_count,
  output logic [5:0]  out_trap_count
);
  localparam int PM  = (TRAP_BYTES < IN_BYTES) ? TRAP_BYTES : IN_BYTES;
  localparam int TEW = LEN_W + 8 * PM;
  localparam int BAW = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1;
  localparam int TAW = (TRAP_ENTRIES > 1) ? $clog2(TRAP_ENTRIES) : 1;
  localparam int BCW = $clog2(BP_ENTRIES + 1);
  localparam int TCW = $clog2(TRAP_ENTRIES + 1);
  localparam int IW  = (BCW > TCW) ? BCW : TCW;

  func_t            func_r;
  logic [15:0]      addr_r;
  logic [LEN_W-1:0] plen_r;
  logic [7:0]       byte_r [IN_BYTES];
  logic [BCW-1:0]   bp_used_r;
  logic [TCW-1:0]   trap_used_r;
  logic [IW-1:0]    idx_r, limit_r, rd_idx_r, found_idx_r;
  logic             run_r, shift_r, stop_r, rd_vld_r, found_r;
  logic             hitb_r, hitt_r;
  logic             obp_r, otrap_r;
  st_t              ost_r;

  logic [LEN_W-1:0] plen_sat;
  logic             issue;
  logic [IW-1:0]    bp_used_x, trap_used_x;
  logic [15:0]      bp_rdata;
  logic [TEW-1:0]   trap_rdata, trap_new;
  logic [LEN_W-1:0] t_len;
  logic             bp_m, t_cov, t_eq;
  logic             bp_we, trap_we;
  logic [BAW-1:0]   bp_waddr;
  logic [TAW-1:0]   trap_waddr;
  logic [15:0]      bp_wdata;
  logic [TEW-1:0]   trap_wdata;

  assign plen_sat = (in_pattern_len > LEN_W'(PM)) ? LEN_W'(PM) : in_pattern_len;
  assign bp_used_x   = IW'(bp_used_r);
  assign trap_used_x = IW'(trap_used_r);
  assign issue = run_r && (idx_r < limit_r) && !(stop_r && found_r);

  // table memories; shift writes trail the read pointer by one entry
  btmu_ram #(.W(16), .D(BP_ENTRIES)) u_bp_ram (
    .clk(clk), .we(bp_we), .waddr(bp_waddr), .wdata(bp_wdata),
    .raddr(idx_r[BAW-1:0]), .rdata(bp_rdata)
  );
  btmu_ram #(.W(TEW), .D(TRAP_ENTRIES)) u_trap_ram (
    .clk(clk), .we(trap_we), .waddr(trap_waddr), .wdata(trap_wdata),
    .raddr(idx_r[TAW-1:0]), .rdata(trap_rdata)
  );

  assign t_len = trap_rdata[TEW-1 -: LEN_W];

  always_comb begin
    bp_m  = rd_vld_r && (rd_idx_r < bp_used_x) && (bp_rdata == addr_r);
    t_cov = rd_vld_r && (rd_idx_r < trap_used_x);
    t_eq  = t_cov && (t_len == plen_r);
    for (int j = 0; j < PM; j++) begin
      if (!((LEN_W'(j) >= t_len) || (trap_rdata[8*j +: 8] == byte_r[j]))) t_cov = 1'b0;
      if (!((LEN_W'(j) >= plen_r) || (trap_rdata[8*j +: 8] == byte_r[j]))) t_eq = 1'b0;
    end
    trap_new = '0;
    trap_new[TEW-1 -: LEN_W] = plen_r;
    for (int j = 0; j < PM; j++)
      if (LEN_W'(j) < plen_r) trap_new[8*j +: 8] = byte_r[j];
  end

  always_comb begin
    bp_we      = 1'b0;
    trap_we    = 1'b0;
    bp_waddr   = BAW'(bp_used_r);
    trap_waddr = TAW'(trap_used_r);
    bp_wdata   = addr_r;
    trap_wdata = trap_new;
    if (shift_r && rd_vld_r) begin
      bp_waddr   = BAW'(rd_idx_r - IW'(1));
      trap_waddr = TAW'(rd_idx_r - IW'(1));
      bp_wdata   = bp_rdata;
      trap_wdata = trap_rdata;
      bp_we      = (func_r == F_RM_BP);
      trap_we    = (func_r == F_RM_TRAP);
    end else if (cmd.apply) begin
      bp_we   = (func_r == F_SET_BP) && !found_r && (bp_used_r < BCW'(BP_ENTRIES));
      trap_we = (func_r == F_ADD_TRAP) && (plen_r != '0)
                && (trap_used_r < TCW'(TRAP_ENTRIES));
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= func_t'(in_func);
      addr_r    <= in_addr;
      plen_r    <= plen_sat;
      byte_r[0] <= in_byte0;
      byte_r[1] <= in_byte1;
      byte_r[2] <= in_byte2;
      byte_r[3] <= in_byte3;
    end
    if (rd_vld_r && !shift_r) begin
      if (bp_m)  hitb_r <= 1'b1;
      if (t_cov) hitt_r <= 1'b1;
      if (stop_r && !found_r && ((func_r == F_RM_TRAP) ? t_eq : bp_m))
        found_idx_r <= rd_idx_r;
    end
    if (cmd.load) begin
      hitb_r <= 1'b0;
      hitt_r <= 1'b0;
    end
    rd_idx_r <= idx_r;
    if (cmd.run_start) begin
      shift_r <= cmd.run_shift;
      stop_r  <= (func_r != F_CHECK) && !cmd.run_shift;
      if (cmd.run_shift) begin
        idx_r   <= found_idx_r + IW'(1);
        limit_r <= (func_r == F_RM_TRAP) ? trap_used_x : bp_used_x;
      end else begin
        idx_r <= '0;
        case (func_r)
          F_CHECK:   limit_r <= (bp_used_x > trap_used_x) ? bp_used_x : trap_used_x;
          F_RM_TRAP: limit_r <= trap_used_x;
          default:   limit_r <= bp_used_x;
        endcase
      end
    end else if (issue) begin
      idx_r <= idx_r + IW'(1);
    end
    if (cmd.apply) begin
      obp_r   <= (func_r == F_CHECK) && bp_en && hitb_r;
      otrap_r <= (func_r == F_CHECK) && trap_en && hitt_r;
      case (func_r)
        F_SET_BP:   ost_r <= found_r ? ST_DUP :
                             (bp_used_r >= BCW'(BP_ENTRIES)) ? ST_FULL : ST_OK;
        F_RM_BP:    ost_r <= found_r ? ST_OK : ST_NOTFOUND;
        F_ADD_TRAP: ost_r <= (plen_r == '0) ? ST_EMPTY :
                             (trap_used_r >= TCW'(TRAP_ENTRIES)) ? ST_FULL : ST_OK;
        F_RM_TRAP:  ost_r <= (plen_r == '0) ? ST_EMPTY :
                             found_r ? ST_OK : ST_NOTFOUND;
        default:    ost_r <= ST_OK;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_used_r   <= '0;
      trap_used_r <= '0;
      run_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (cmd.load) begin
        run_r   <= 1'b0;
        found_r <= 1'b0;
      end else if (cmd.run_start) begin
        run_r <= 1'b1;
      end
      if (rd_vld_r && !shift_r && stop_r && ((func_r == F_RM_TRAP) ? t_eq : bp_m))
        found_r <= 1'b1;
      if (cmd.apply) begin
        case (func_r)
          F_SET_BP:   if (bp_we) bp_used_r <= bp_used_r + BCW'(1);
          F_RM_BP:    if (found_r) bp_used_r <= bp_used_r - BCW'(1);
          F_CLR_BP:   bp_used_r <= '0;
          F_ADD_TRAP: if (trap_we) trap_used_r <= trap_used_r + TCW'(1);
          F_RM_TRAP:  if (found_r && plen_r != '0) trap_used_r <= trap_used_r - TCW'(1);
          F_CLR_TRAP: trap_used_r <= '0;
          default: ;
        endcase
      end
    end
  end

  assign stat.func      = func_r;
  assign stat.plen_zero = (plen_r == '0);
  assign stat.found     = found_r;
  assign stat.run_done  = !issue && !rd_vld_r;

  assign out_bp_hit     = obp_r;
  assign out_trap_hit   = otrap_r;
  assign out_status     = ost_r;
  assign out_bp_count   = 7'(bp_used_r);
  assign out_trap_count = 6'(trap_used_r);

  `BTMU_ASSERT_IMP(a_bp_bound, 1'b1, bp_used_r <= BCW'(BP_ENTRIES), "bp count overflow")
  `BTMU_ASSERT_IMP(a_trap_bound, 1'b1, trap_used_r <= TCW'(TRAP_ENTRIES), "trap count overflow")
  `BTMU_ASSERT_IMP(a_shift_addr, rd_vld_r && shift_r, rd_idx_r != '0, "shift write below entry 0")
  `BTMU_ASSERT_NXT(a_load_clears, cmd.load, !found_r && !run_r, "stale scan state after load")
endmodule

// File: rtl/breakpoint_trap_match_unit.sv
// Breakpoint/trap match unit. A check scans up to the larger of the two table counts,
// set/remove breakpoint scan the breakpoint table and remove trap scans the trap table;
// a remove that hits then shifts the later entries down one place, with nothing to move when
// the match is the last entry. Clears, trap adds, zero-length trap removes and func 7 skip the scan.
// The next transaction is taken the cycle after the result strobe; the receiver cannot stall.
// Reset zeroes both counts and sets both enables; table contents stay undefined, no clear pass.
module breakpoint_trap_match_unit import btmu_pkg::*; #(
  parameter int BP_ENTRIES   = BP_ENTRIES_DEF,
  parameter int TRAP_ENTRIES = TRAP_ENTRIES_DEF,
  parameter int TRAP_BYTES   = TRAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_addr,
  input  logic [2:0]  in_pattern_len,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  input  logic [7:0]  in_byte3,
  output logic        out_strobe,
  output logic        out_bp_hit,
  output logic        out_trap_hit,
  output logic [2:0]  out_status,
  output logic [6:0]  out_bp_count,
  output logic [5:0]  out_trap_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cmd_t  cmd;
  stat_t stat;
  logic  bp_en_r, trap_en_r;
  logic  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_en_r   <= 1'b1;
      trap_en_r <= 1'b1;
    end else if (psel && penable && pwrite) begin
      if (reg_sel == REG_BP_EN) bp_en_r   <= pwdata[0];
      else                      trap_en_r <= pwdata[0];
    end
  end

  assign prdata = {31'b0, (reg_sel == REG_BP_EN) ? bp_en_r : trap_en_r};

  btmu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .strobe(out_strobe), .cmd(cmd), .stat(stat)
  );

  btmu_dp #(
    .BP_ENTRIES(BP_ENTRIES), .TRAP_ENTRIES(TRAP_ENTRIES), .TRAP_BYTES(TRAP_BYTES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .bp_en(bp_en_r), .trap_en(trap_en_r),
    .in_func(in_func), .in_addr(in_addr), .in_pattern_len(in_pattern_len),
    .in_byte0(in_byte0), .in_byte1(in_byte1), .in_byte2(in_byte2), .in_byte3(in_byte3),
    .out_bp_hit(out_bp_hit), .out_trap_hit(out_trap_hit), .out_status(out_status),
    .out_bp_count(out_bp_count), .out_trap_count(out_trap_count)
  );
endmodule

// File: tb/breakpoint_trap_match_unit_tb.sv
// Testbench for breakpoint_trap_match_unit: directed and random commands checked
// against an in-bench model of both tables. Depends on btmu_pkg and the RTL.
module breakpoint_trap_match_unit_tb;
  import btmu_pkg::*;

  localparam int BP_MAX   = 64;
  localparam int TRAP_MAX = 32;
  localparam int PAT_MAX  = 4;
  localparam int WATCHDOG = 20000;
  localparam logic [2:0] F_UNUSED = 3'd7;

  typedef struct packed {
    logic       bp_hit;
    logic       trap_hit;
    logic [2:0] status;
    logic [6:0] bp_count;
    logic [5:0] trap_count;
  } result_t;

  logic clk, rst_n, start, busy;
  logic [2:0] in_func, in_pattern_len;
  logic [15:0] in_addr;
  logic [7:0] in_byte0, in_byte1, in_byte2, in_byte3;
  logic out_strobe, out_bp_hit, out_trap_hit;
  logic [2:0] out_status;
  logic [6:0] out_bp_count;
  logic [5:0] out_trap_count;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  breakpoint_trap_match_unit uut (.*);

  // predictor state
  logic [15:0] bp_tab[BP_MAX];
  int          bp_n;
  logic [2:0]  tr_len[TRAP_MAX];
  logic [7:0]  tr_b[TRAP_MAX][4];
  int          tr_n;
  logic        bp_en, tr_en;

  result_t expected_q[$];
  int errors, idle_pct, idle_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic result_t predict(logic [2:0] f, logic [15:0] a, logic [2:0] pl,
                                      logic [7:0] b[4]);
    result_t r;
    int i, j, len;
    logic ok;
    r = '0;
    len = (pl > PAT_MAX) ? PAT_MAX : pl;
    case (f)
      F_CHECK: begin
        if (bp_en) for (i = 0; i < bp_n; i++) if (bp_tab[i] == a) r.bp_hit = 1;
        if (tr_en) for (i = 0; i < tr_n; i++) begin
          ok = 1;
          for (j = 0; j < tr_len[i]; j++) if (tr_b[i][j] != b[j]) ok = 0;
          if (ok) r.trap_hit = 1;
        end
      end
      F_SET_BP: begin
        for (i = 0; i < bp_n; i++) if (bp_tab[i] == a) r.status = ST_DUP;
        if (r.status == ST_OK) begin
          if (bp_n >= BP_MAX) r.status = ST_FULL;
          else begin bp_tab[bp_n] = a; bp_n++; end
        end
      end
      F_RM_BP: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < bp_n; i++) if (bp_tab[i] == a) begin
          for (j = i; j + 1 < bp_n; j++) bp_tab[j] = bp_tab[j + 1];
          bp_n--;
          r.status = ST_OK;
          break;
        end
      end
      F_CLR_BP: bp_n = 0;
      F_ADD_TRAP: begin
        if (len == 0) r.status = ST_EMPTY;
        else if (tr_n >= TRAP_MAX) r.status = ST_FULL;
        else begin
          tr_len[tr_n] = len;
          for (j = 0; j < 4; j++) tr_b[tr_n][j] = (j < len) ? b[j] : 8'h00;
          tr_n++;
        end
      end
      F_RM_TRAP: begin
        if (len == 0) r.status = ST_EMPTY;
        else begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < tr_n; i++) begin
            ok = (tr_len[i] == len);
            for (j = 0; j < len; j++) if (tr_b[i][j] != b[j]) ok = 0;
            if (ok) begin
              for (j = i; j + 1 < tr_n; j++) begin
                tr_len[j] = tr_len[j + 1];
                tr_b[j] = tr_b[j + 1];
              end
              tr_n--;
              r.status = ST_OK;
              break;
            end
          end
        end
      end
      F_CLR_TRAP: tr_n = 0;
      default: ;
    endcase
    r.bp_count = bp_n[6:0];
    r.trap_count = tr_n[5:0];
    return r;
  endfunction

  // one command transaction; pattern bytes double as fetched bytes for checks.
  // start stays high on return until the next call or drain drives it again.
  task automatic send_cmd(logic [2:0] f, logic [15:0] a, logic [2:0] pl,
                          logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
    logic [7:0] b[4];
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    b[0] = b0; b[1] = b1; b[2] = b2; b[3] = b3;
    in_func <= f; in_addr <= a; in_pattern_len <= pl;
    in_byte0 <= b0; in_byte1 <= b1; in_byte2 <= b2; in_byte3 <= b3;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict(f, a, pl, b));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(int idx, logic v);
    drain();
    psel <= 1; pwrite <= 1; paddr <= 3'(4 * idx); pwdata <= {31'd0, v};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_BP_EN) bp_en = v; else tr_en = v;
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_strobe) begin
      got = {out_bp_hit, out_trap_hit, out_status, out_bp_count, out_trap_count};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.bp_hit !== want.bp_hit)
          $display("%0t bp_hit exp %0d got %0d", $time, want.bp_hit, got.bp_hit);
        if (got.trap_hit !== want.trap_hit)
          $display("%0t trap_hit exp %0d got %0d", $time, want.trap_hit, got.trap_hit);
        if (got.status !== want.status)
          $display("%0t status exp %0d got %0d", $time, want.status, got.status);
        if (got.bp_count !== want.bp_count)
          $display("%0t bp_count exp %0d got %0d", $time, want.bp_count, got.bp_count);
        if (got.trap_count !== want.trap_count)
          $display("%0t trap_count exp %0d got %0d", $time, want.trap_count, got.trap_count);
        if (got !== want) errors++;
      end
    end
  end

  // watchdog: cycles with no accepted transaction and no result strobe
  always @(posedge clk) begin
    if (!rst_n || out_strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog timeout");
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed();
    send_cmd(F_CHECK, 16'h0000, 0, 0, 0, 0, 0);
    send_cmd(F_RM_BP, 16'hFFFF, 0, 0, 0, 0, 0);
    send_cmd(F_SET_BP, 16'h0000, 0, 0, 0, 0, 0);
    send_cmd(F_SET_BP, 16'hFFFF, 0, 0, 0, 0, 0);
    send_cmd(F_SET_BP, 16'hFFFF, 0, 0, 0, 0, 0);
    send_cmd(F_CHECK, 16'hFFFF, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(F_ADD_TRAP, 16'h1234, 0, 8'hAA, 0, 0, 0);
    send_cmd(F_RM_TRAP, 16'h1234, 0, 8'hAA, 0, 0, 0);
    send_cmd(F_ADD_TRAP, 0, 1, 8'hC3, 8'h11, 8'h22, 8'h33);
    send_cmd(F_ADD_TRAP, 0, 7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(F_ADD_TRAP, 0, 4, 8'h00, 8'h00, 8'h00, 8'h00);
    send_cmd(F_ADD_TRAP, 0, 1, 8'hC3, 8'h00, 8'h00, 8'h00);
    send_cmd(F_CHECK, 16'h0000, 0, 8'hC3, 8'h99, 8'h99, 8'h99);
    send_cmd(F_RM_TRAP, 0, 2, 8'hC3, 8'h11, 0, 0);
    send_cmd(F_RM_TRAP, 0, 1, 8'hC3, 8'h55, 0, 0);
    send_cmd(F_RM_TRAP, 0, 5, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(F_CHECK, 16'h0000, 7, 8'hC3, 0, 0, 0);
    send_cmd(F_UNUSED, 16'hFFFF, 7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(F_RM_BP, 16'h0000, 0, 0, 0, 0, 0);
    send_cmd(F_CLR_BP, 0, 0, 0, 0, 0, 0);
    send_cmd(F_CLR_TRAP, 0, 0, 0, 0, 0, 0);
  endtask

  // fill both tables past capacity to reach the full status
  task automatic test_full_tables();
    for (int i = 0; i < BP_MAX + 3; i++)
      send_cmd(F_SET_BP, 16'(i * 977), 0, 0, 0, 0, 0);
    for (int i = 0; i < TRAP_MAX + 3; i++)
      send_cmd(F_ADD_TRAP, 0, 3'($urandom_range(1, 4)), 8'(i), 8'($urandom),
               8'($urandom), 8'($urandom));
    send_cmd(F_SET_BP, 16'(5 * 977), 0, 0, 0, 0, 0);
    send_cmd(F_CHECK, 16'(63 * 977), 0, 8'd7, 0, 0, 0);
    send_cmd(F_RM_BP, 16'(10 * 977), 0, 0, 0, 0, 0);
    send_cmd(F_RM_TRAP, 0, 1, 8'd0, 0, 0, 0);
  endtask

  // small address and byte pools so hits, duplicates and removals are common
  task automatic test_random(int n);
    logic [15:0] a;
    logic [7:0] b0;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      a = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15) * 4099);
      b0 = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7) * 37);
      if (k < 30)
        send_cmd(F_CHECK, a, 3'($urandom), b0, 8'($urandom_range(3)),
                 8'($urandom), 8'($urandom));
      else if (k < 50) send_cmd(F_SET_BP, a, 3'($urandom), 0, 0, 0, 0);
      else if (k < 62) send_cmd(F_RM_BP, a, 0, 8'($urandom), 0, 0, 0);
      else if (k < 78)
        send_cmd(F_ADD_TRAP, a, 3'($urandom), b0, 8'($urandom_range(3)),
                 8'($urandom), 8'($urandom));
      else if (k < 92)
        send_cmd(F_RM_TRAP, a, 3'($urandom), b0, 8'($urandom_range(3)),
                 8'($urandom), 8'($urandom));
      else if (k < 95) send_cmd(F_CLR_BP, a, 0, 0, 0, 0, 0);
      else if (k < 98) send_cmd(F_CLR_TRAP, a, 0, 0, 0, 0, 0);
      else send_cmd(F_UNUSED, a, 3'($urandom), b0, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_enables();
    write_reg(REG_BP_EN, 0);
    write_reg(REG_TRAP_EN, 0);
    idle_pct = 0;
    test_random(200);
    write_reg(REG_BP_EN, 1);
    idle_pct = 82;
    test_random(200);
    write_reg(REG_TRAP_EN, 1);
    write_reg(REG_BP_EN, 0);
    idle_pct = 38;
    test_random(200);
    write_reg(REG_BP_EN, 1);
  endtask

  initial begin
    errors = 0; idle_pct = 0; idle_cycles = 0;
    bp_en = 1; tr_en = 1; bp_n = 0; tr_n = 0;
    rst_n = 0; start = 0;
    in_func = 0; in_addr = 0; in_pattern_len = 0;
    in_byte0 = 0; in_byte1 = 0; in_byte2 = 0; in_byte3 = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    test_directed();
    test_full_tables();
    idle_pct = 0;
    test_random(300);
    drain();                       // sender holds off until all results are back
    idle_pct = 82;
    test_random(300);
    idle_pct = 38;
    test_random(300);
    test_enables();
    drain();
    $display("covered: all commands, full and empty tables, duplicates, length saturation,");
    $display("enable settings and idle phases; %0d mismatches", errors);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
